@@ hdl/nv12sra_pkg.sv @@
// shared types, constants and register codes for the nv12 scale/rotate address generator
package nv12sra_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int FIELD_W    = 12;
	localparam int EXT_W      = 13;
	localparam int PITCH_W    = 14;
	localparam int STEP_W     = 24;
	localparam int ADDR_W     = 27;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH    = 3'd0,
		REG_SRC_HEIGHT   = 3'd1,
		REG_ROW_PITCH    = 3'd2,
		REG_SURFACE_ROWS = 3'd3,
		REG_STEP_X       = 3'd4,
		REG_STEP_Y       = 3'd5,
		REG_ROTATION     = 3'd6,
		REG_MIRROR_MODE  = 3'd7
	} cfg_reg_t;

	// rotation codes
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// mirror_mode bits
	localparam int MIRROR_H_BIT = 0;
	localparam int MIRROR_V_BIT = 1;

	typedef struct packed {
		logic [EXT_W-1:0]   src_width;
		logic [EXT_W-1:0]   src_height;
		logic [PITCH_W-1:0] row_pitch;
		logic [PITCH_W-1:0] surface_rows;
		logic [STEP_W-1:0]  step_x;
		logic [STEP_W-1:0]  step_y;
		logic [1:0]         rotation;
		logic [1:0]         mirror_mode;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		src_width:    13'd1920,
		src_height:   13'd1080,
		row_pitch:    14'd1920,
		surface_rows: 14'd1080,
		step_x:       24'd65536,
		step_y:       24'd65536,
		rotation:     ROT_0,
		mirror_mode:  2'd0
	};

	typedef struct packed {
		logic [FIELD_W-1:0] out_col;
		logic [FIELD_W-1:0] out_row;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] src_col;
		logic [FIELD_W-1:0] src_row;
		logic [ADDR_W-1:0]  luma_addr;
		logic [ADDR_W-1:0]  chroma_addr;
		logic               in_range;
	} out_item_t;

	// integer source position after rotation, mirroring and bounds check
	typedef struct packed {
		logic             in_range;
		logic [EXT_W-1:0] col;
		logic [EXT_W-1:0] row;
	} map_t;

endpackage

@@ hdl/nv12sra_scale.sv @@
// stage 1: scales the output coordinate by the q-format step ratios
module nv12sra_scale #(
	parameter int COORD_BITS = nv12sra_pkg::COORD_BITS_DEF,
	localparam int PROD_W = COORD_BITS + nv12sra_pkg::STEP_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  nv12sra_pkg::in_item_t         up_item,
	input  logic [nv12sra_pkg::STEP_W-1:0] step_x,
	input  logic [nv12sra_pkg::STEP_W-1:0] step_y,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output logic [PROD_W-1:0]             px_s1,
	output logic [PROD_W-1:0]             py_s1
);

	logic                  valid_s1;
	logic [COORD_BITS-1:0] col_c;
	logic [COORD_BITS-1:0] row_c;

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;

	// coordinate taken in its low COORD_BITS bits
	assign col_c = COORD_BITS'(up_item.out_col);
	assign row_c = COORD_BITS'(up_item.out_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			px_s1 <= PROD_W'(col_c) * PROD_W'(step_x);
			py_s1 <= PROD_W'(row_c) * PROD_W'(step_y);
		end
	end

endmodule

@@ hdl/nv12sra_map.sv @@
// stage 2: rotation, mirroring, truncation toward zero and bounds check
module nv12sra_map #(
	parameter int COORD_BITS = nv12sra_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = nv12sra_pkg::FRAC_BITS_DEF,
	localparam int PROD_W = COORD_BITS + nv12sra_pkg::STEP_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  logic [PROD_W-1:0]   px,
	input  logic [PROD_W-1:0]   py,
	input  nv12sra_pkg::cfg_t   cfg,
	output logic                dn_valid,
	input  logic                dn_ready,
	output nv12sra_pkg::map_t   dn_map
);

	localparam int EXT_W = nv12sra_pkg::EXT_W;
	localparam int IP_W  = PROD_W - FRAC_BITS;
	localparam int D_W   = ((IP_W > EXT_W) ? IP_W : EXT_W) + 2;

	// one axis: plain integer part, or reflection (ext-1) - p truncated toward zero
	function automatic logic [EXT_W:0] fold_axis(
		input logic [IP_W-1:0]  ip,
		input logic             frac,
		input logic             refl,
		input logic [EXT_W-1:0] ext
	);
		logic [D_W-1:0] d;
		logic [D_W-1:0] v;
		logic           ok;
		d = D_W'(ext) - D_W'(1) - D_W'(ip);
		if (refl) begin
			// positive result floors down by the fraction, negative one rounds up
			if (!d[D_W-1] && (d != '0)) begin
				v = d - D_W'(frac);
			end else begin
				v = d;
			end
		end else begin
			v = D_W'(ip);
		end
		ok = !v[D_W-1] && (v < D_W'(ext));
		return {ok, v[EXT_W-1:0]};
	endfunction

	logic               valid_s2;
	nv12sra_pkg::map_t  map_s2;
	nv12sra_pkg::map_t  map_c;
	logic [IP_W-1:0]    ipx;
	logic [IP_W-1:0]    ipy;
	logic               fx;
	logic               fy;
	logic               refl_x;
	logic               refl_y;
	logic [EXT_W:0]     fold_x;
	logic [EXT_W:0]     fold_y;

	assign up_ready = !valid_s2 || dn_ready;
	assign dn_valid = valid_s2;
	assign dn_map   = map_s2;

	always_comb begin
		ipx = px[PROD_W-1 -: IP_W];
		ipy = py[PROD_W-1 -: IP_W];
		fx  = |px[FRAC_BITS-1:0];
		fy  = |py[FRAC_BITS-1:0];
		refl_x = ((cfg.rotation == nv12sra_pkg::ROT_90) || (cfg.rotation == nv12sra_pkg::ROT_180))
			^ cfg.mirror_mode[nv12sra_pkg::MIRROR_H_BIT];
		refl_y = ((cfg.rotation == nv12sra_pkg::ROT_180) || (cfg.rotation == nv12sra_pkg::ROT_270))
			^ cfg.mirror_mode[nv12sra_pkg::MIRROR_V_BIT];
		// quarter turns swap the axes and drop the fractions first
		if ((cfg.rotation == nv12sra_pkg::ROT_90) || (cfg.rotation == nv12sra_pkg::ROT_270)) begin
			fold_x = fold_axis(ipy, 1'b0, refl_x, cfg.src_width);
			fold_y = fold_axis(ipx, 1'b0, refl_y, cfg.src_height);
		end else begin
			fold_x = fold_axis(ipx, fx, refl_x, cfg.src_width);
			fold_y = fold_axis(ipy, fy, refl_y, cfg.src_height);
		end
		map_c.in_range = fold_x[EXT_W] && fold_y[EXT_W];
		map_c.col      = fold_x[EXT_W-1:0];
		map_c.row      = fold_y[EXT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			map_s2 <= map_c;
		end
	end

`ifndef NO_ASSERTIONS
	a_map_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && dn_map.in_range |->
			(dn_map.col < cfg.src_width) && (dn_map.row < cfg.src_height))
		else $error("in-range position outside the frame");
`endif

endmodule

@@ hdl/nv12sra_addr.sv @@
// stages 3 and 4: row products, then luma and chroma address sums
module nv12sra_addr (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_ready,
	input  nv12sra_pkg::map_t      up_map,
	input  nv12sra_pkg::cfg_t      cfg,
	output logic                   dn_valid,
	input  logic                   dn_ready,
	output nv12sra_pkg::out_item_t dn_item
);

	localparam int EXT_W   = nv12sra_pkg::EXT_W;
	localparam int PITCH_W = nv12sra_pkg::PITCH_W;
	localparam int ADDR_W  = nv12sra_pkg::ADDR_W;
	localparam int FIELD_W = nv12sra_pkg::FIELD_W;

	logic                   valid_s3;
	logic                   valid_s4;
	logic                   rdy_s3;
	logic                   rdy_s4;
	logic                   rng_s3;
	logic [EXT_W-1:0]       col_s3;
	logic [FIELD_W-1:0]     row_s3;
	logic [ADDR_W-1:0]      lprod_s3;
	logic [ADDR_W-1:0]      cprod_s3;
	logic [ADDR_W-1:0]      base_s3;
	logic [EXT_W+PITCH_W-1:0]   lprod_c;
	logic [EXT_W+PITCH_W-2:0]   cprod_c;
	logic [2*PITCH_W-1:0]       base_c;
	logic [EXT_W-2:0]       half_row;
	nv12sra_pkg::out_item_t item_c;
	nv12sra_pkg::out_item_t out_s4;

	assign rdy_s4   = !valid_s4 || dn_ready;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign up_ready = rdy_s3;
	assign dn_valid = valid_s4;
	assign dn_item  = out_s4;

	// three independent products
	always_comb begin
		half_row = up_map.row[EXT_W-1:1];
		lprod_c  = (EXT_W+PITCH_W)'(up_map.row) * (EXT_W+PITCH_W)'(cfg.row_pitch);
		cprod_c  = (EXT_W+PITCH_W-1)'(half_row) * (EXT_W+PITCH_W-1)'(cfg.row_pitch);
		base_c   = (2*PITCH_W)'(cfg.row_pitch) * (2*PITCH_W)'(cfg.surface_rows);
	end

	// final sums; out of frame gives all zero fields
	always_comb begin
		item_c = '0;
		if (rng_s3) begin
			item_c.in_range    = 1'b1;
			item_c.src_col     = col_s3[FIELD_W-1:0];
			item_c.src_row     = row_s3;
			item_c.luma_addr   = ADDR_W'(col_s3) + lprod_s3;
			item_c.chroma_addr = base_s3 + ADDR_W'({col_s3[EXT_W-1:1], 1'b0}) + cprod_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				valid_s3 <= up_valid;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_s3) begin
			rng_s3   <= up_map.in_range;
			col_s3   <= up_map.col;
			row_s3   <= up_map.row[FIELD_W-1:0];
			lprod_s3 <= lprod_c[ADDR_W-1:0];
			cprod_s3 <= ADDR_W'(cprod_c);
			base_s3  <= base_c[ADDR_W-1:0];
		end
		if (valid_s3 && rdy_s4) begin
			out_s4 <= item_c;
		end
	end

endmodule

@@ hdl/nv12_scale_rotate_address_gen_unit.sv @@
// top level of the nv12 nearest-neighbour scale, rotate and mirror address generator
//
// in channel: one output pixel coordinate per item (in_valid, in_stall, in_item)
// out channel: one result item per input item, in order (out_valid, out_stall, out_item)
// an item moves at a rising edge with valid high and stall low on its channel
// config port: cfg_we writes cfg_data into register cfg_index; write
// only while no item is in flight
// pipeline: scale multiply, rotate/mirror/bounds, address products, address sums;
// four register stages, one for each step above, with the result offered from stage 4
// throughput: one item per clock while out_stall is low, since each of the four
// stages can take a new item while handing its last one on
// stall: each stage holds its item while the next is full, bubbles close up, and
// in_stall rises only when all four stages are full and out_stall is high
// reset: arst_n clears all stage valid bits and loads the register defaults
// (1920 x 1080 frame, pitch 1920, unit steps, no rotation, no mirroring)
// out of frame positions give in_range low and zero coordinates and addresses
module nv12_scale_rotate_address_gen_unit #(
	parameter int COORD_BITS = nv12sra_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = nv12sra_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  nv12sra_pkg::in_item_t              in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output nv12sra_pkg::out_item_t             out_item,
	input  logic                               cfg_we,
	input  logic [nv12sra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nv12sra_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int PROD_W = COORD_BITS + nv12sra_pkg::STEP_W;

	nv12sra_pkg::cfg_t cfg_q;

	// stage links
	logic              scale_ready;
	logic              scale_valid;
	logic [PROD_W-1:0] px_s1;
	logic [PROD_W-1:0] py_s1;
	logic              map_ready;
	logic              map_valid;
	nv12sra_pkg::map_t map_s2;
	logic              addr_ready;

	// configuration registers, each taking the low bits of the written word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= nv12sra_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				nv12sra_pkg::REG_SRC_WIDTH: begin
					cfg_q.src_width <= cfg_data[nv12sra_pkg::EXT_W-1:0];
				end
				nv12sra_pkg::REG_SRC_HEIGHT: begin
					cfg_q.src_height <= cfg_data[nv12sra_pkg::EXT_W-1:0];
				end
				nv12sra_pkg::REG_ROW_PITCH: begin
					cfg_q.row_pitch <= cfg_data[nv12sra_pkg::PITCH_W-1:0];
				end
				nv12sra_pkg::REG_SURFACE_ROWS: begin
					cfg_q.surface_rows <= cfg_data[nv12sra_pkg::PITCH_W-1:0];
				end
				nv12sra_pkg::REG_STEP_X: begin
					cfg_q.step_x <= cfg_data[nv12sra_pkg::STEP_W-1:0];
				end
				nv12sra_pkg::REG_STEP_Y: begin
					cfg_q.step_y <= cfg_data[nv12sra_pkg::STEP_W-1:0];
				end
				nv12sra_pkg::REG_ROTATION: begin
					cfg_q.rotation <= cfg_data[1:0];
				end
				nv12sra_pkg::REG_MIRROR_MODE: begin
					cfg_q.mirror_mode <= cfg_data[1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign in_stall = !scale_ready;

	// stage 1: q-format source position
	nv12sra_scale #(
		.COORD_BITS (COORD_BITS)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (scale_ready),
		.up_item  (in_item),
		.step_x   (cfg_q.step_x),
		.step_y   (cfg_q.step_y),
		.dn_valid (scale_valid),
		.dn_ready (map_ready),
		.px_s1    (px_s1),
		.py_s1    (py_s1)
	);

	// stage 2: rotation, mirror, truncation and frame check
	nv12sra_map #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (scale_valid),
		.up_ready (map_ready),
		.px       (px_s1),
		.py       (py_s1),
		.cfg      (cfg_q),
		.dn_valid (map_valid),
		.dn_ready (addr_ready),
		.dn_map   (map_s2)
	);

	// stages 3 and 4: luma and interleaved chroma addresses
	nv12sra_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (map_valid),
		.up_ready (addr_ready),
		.up_map   (map_s2),
		.cfg      (cfg_q),
		.dn_valid (out_valid),
		.dn_ready (!out_stall),
		.dn_item  (out_item)
	);

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the pipeline had room");

	a_out_of_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.in_range |->
			(out_item.src_col == '0) && (out_item.src_row == '0) &&
			(out_item.luma_addr == '0) && (out_item.chroma_addr == '0))
		else $error("out of frame item with non-zero fields");

	a_no_output_after_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result offered straight after reset");
`endif

endmodule
